// ----- rtl/deque_with_index_and_search_unit_defines.svh -----
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_INDEX_AND_SEARCH_UNIT_DEFINES_SVH
`define DEQUE_WITH_INDEX_AND_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dwis_pkg.sv -----
// Shared types, constants and ring helpers for the deque unit.
`default_nettype none

package dwis_pkg;

	localparam int DEPTH       = 16;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int POS_W       = 4;
	localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int VAL_W       = 32;
	localparam int CMD_W       = 3;
	localparam int ELEM_CNT_W  = 5;
	localparam int STAT_W      = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// command codes on the input stream
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd6;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_READ,
		OP_WRITE,
		OP_SEARCH,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		logic [CNT_W-1:0]        count;
		logic [STAT_W-1:0]       status;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SRCH
	} back_state_t;

	// (base + off) mod DEPTH, both operands below DEPTH
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
			input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// (base - 1) mod DEPTH
	function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] base);
		logic [PTR_W-1:0] r;
		if (base == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = base - PTR_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dwis_front.sv -----
// Front end: takes input items, decodes the command and feeds the queue.
`default_nettype none

module dwis_front
	import dwis_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  wire q_status_t             q_stat,
	output logic                       q_push,
	output op_t                        q_data
);

	logic [CMD_W-1:0] cmd;
	op_kind_t         kind;
	logic             seen_q;

	assign cmd = s_axis_tdata[CMD_W-1:0];

	always_comb begin
		case (cmd)
			CMD_PUSH_FRONT: kind = OP_PUSH_FRONT;
			CMD_PUSH_BACK:  kind = OP_PUSH_BACK;
			CMD_POP_FRONT:  kind = OP_POP_FRONT;
			CMD_POP_BACK:   kind = OP_POP_BACK;
			CMD_READ:       kind = OP_READ;
			CMD_WRITE:      kind = OP_WRITE;
			CMD_SEARCH:     kind = OP_SEARCH;
			default:        kind = OP_NOP;
		endcase
	end

	// ready only once out of reset and while the queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign s_axis_tready   = seen_q && !q_stat.full;
	assign q_push          = s_axis_tvalid && s_axis_tready;
	assign q_data.kind     = kind;
	assign q_data.position = s_axis_tdata[CMD_W +: POS_W];
	assign q_data.value    = s_axis_tdata[CMD_W + POS_W +: VAL_W];

endmodule

`default_nettype wire

// ----- rtl/dwis_queue.sv -----
// Short command queue between front and back end.
`default_nettype none

module dwis_queue
	import dwis_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire op_t   push_data,
	input  wire logic  pop,
	output op_t        head,
	output q_status_t  stat
);

	op_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dwis_back.sv -----
// Back end: ring store, pointers, search walk and result register.
`default_nettype none

module dwis_back
	import dwis_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire q_status_t              q_stat,
	input  wire op_t                    q_head,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	back_state_t             state_q, state_d;
	logic [PTR_W-1:0]        fp_q, fp_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [PTR_W-1:0]        idx_q, idx_d;
	op_t                     cur_q;
	logic                    out_vld_q;
	res_t                    res_q, res_d;
	logic                    res_ld;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic                    mem_we;
	logic [PTR_W-1:0]        waddr;
	logic [PTR_W-1:0]        raddr;

	logic out_free;
	logic take;
	logic full;
	logic empty;
	logic pos_ok;
	logic hit;
	logic last;

	assign out_free = !out_vld_q || m_axis_tready;
	assign take     = (state_q == BK_IDLE) && !q_stat.empty && out_free;
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pos_ok   = CMP_W'(q_head.position) < CMP_W'(cnt_q);
	assign hit      = (rdata_q == cur_q.value);
	assign last     = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					if (q_head.kind == OP_READ && pos_ok) begin
						state_d = BK_READ;
					end else if (q_head.kind == OP_SEARCH && !empty) begin
						state_d = BK_SRCH;
					end
				end
			end
			BK_READ: state_d = BK_IDLE;
			BK_SRCH: begin
				if (hit || last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath and result
	always_comb begin
		q_pop            = 1'b0;
		mem_we           = 1'b0;
		waddr            = fp_q;
		raddr            = fp_q;
		fp_d             = fp_q;
		cnt_d            = cnt_q;
		idx_d            = idx_q;
		res_ld           = 1'b0;
		res_d.read_value = '0;
		res_d.found      = 1'b0;
		res_d.status     = ST_OK;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					case (q_head.kind)
						OP_PUSH_FRONT: begin
							res_ld = 1'b1;
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								fp_d   = ring_dec(fp_q);
								waddr  = ring_dec(fp_q);
								mem_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						OP_PUSH_BACK: begin
							res_ld = 1'b1;
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								waddr  = ring_add(fp_q, PTR_W'(cnt_q));
								mem_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						OP_POP_FRONT: begin
							res_ld = 1'b1;
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								fp_d  = ring_add(fp_q, PTR_W'(1));
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_POP_BACK: begin
							res_ld = 1'b1;
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_READ: begin
							if (!pos_ok) begin
								res_ld       = 1'b1;
								res_d.status = ST_RANGE;
							end else begin
								raddr = ring_add(fp_q, PTR_W'(q_head.position));
							end
						end
						OP_WRITE: begin
							res_ld = 1'b1;
							if (!pos_ok) begin
								res_d.status = ST_RANGE;
							end else begin
								waddr  = ring_add(fp_q, PTR_W'(q_head.position));
								mem_we = 1'b1;
							end
						end
						OP_SEARCH: begin
							if (empty) begin
								res_ld = 1'b1;
							end else begin
								raddr = fp_q;
								idx_d = '0;
							end
						end
						default: res_ld = 1'b1;
					endcase
				end
			end
			BK_READ: begin
				res_ld           = 1'b1;
				res_d.read_value = rdata_q;
			end
			BK_SRCH: begin
				if (hit || last) begin
					res_ld      = 1'b1;
					res_d.found = hit;
				end else begin
					idx_d = idx_q + PTR_W'(1);
					raddr = ring_add(fp_q, idx_q + PTR_W'(1));
				end
			end
			default: ;
		endcase
		res_d.count = cnt_d;
	end

	// ring store, contents undefined until written
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= q_head.value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		idx_q <= idx_d;
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			fp_q      <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fp_q    <= fp_d;
			cnt_q   <= cnt_d;
			if (res_ld) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {res_q.status, ELEM_CNT_W'(res_q.count), res_q.found,
		res_q.read_value};

endmodule

`default_nettype wire

// ----- rtl/deque_with_index_and_search_unit.sv -----
// Top level of the double-ended queue with indexed access and search.
// A bounded deque of 16 signed 32-bit values kept in a ring store. Each input item carries a
// command (push front/back, pop front/back, read/write at a position from the front, search
// for a value) and yields exactly one result item with the read value, a found flag, the
// element count after the command and a status (ok, empty on pop, position out of range,
// full on push). Faulting commands leave the queue unchanged. Items enter a two-entry
// command queue the cycle they are accepted; the back end takes one command per cycle at
// best. Push, pop, write, no-op and every faulting command finish in the back end's idle
// state; a read also passes through the read state (registered read of the ring store's
// single read port); a search walks the stored elements one per cycle through that same
// read port until the first match or the last element. The input side keeps accepting
// while the queue has room and a result waits in the output register. The ring store has
// no reset: it needs no clearing pass, since only stored elements are ever read.
`default_nettype none

module deque_with_index_and_search_unit
	import dwis_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// s_axis_tdata: cmd[2:0], position[6:3], value[38:7], zero pad[39]
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// m_axis_tdata: read_value[31:0], found[32], element_count[37:33], status[39:38]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	// front -> queue
	logic      q_push;
	op_t       q_in;
	// queue -> back
	op_t       q_head;
	logic      q_pop;
	q_status_t q_stat;

	// decode and admission
	dwis_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	// decouples admission from execution
	dwis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// ring store, pointers, search and result register
	dwis_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ----- rtl/dwis_checker.sv -----
// Port-level checker for the deque unit and its bind.
`default_nettype none

`include "deque_with_index_and_search_unit_defines.svh"

module dwis_checker
	import dwis_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic [ELEM_CNT_W-1:0] MAX_CNT = ELEM_CNT_W'(DEPTH);

	logic [ELEM_CNT_W-1:0] cnt;
	logic [STAT_W-1:0]     stat;
	logic                  found;
	logic [VAL_W-1:0]      rd;
	logic                  vld;
	logic                  stall;

	assign cnt   = m_axis_tdata[37:33];
	assign stat  = m_axis_tdata[39:38];
	assign found = m_axis_tdata[32];
	assign rd    = m_axis_tdata[31:0];
	assign vld   = m_axis_tvalid;
	assign stall = m_axis_tvalid && !m_axis_tready;

	`DWIS_ASSERT_NXT(a_out_hold, clk, arst_n, stall, vld && $stable(m_axis_tdata), "result moved")
	`DWIS_ASSERT_IMP(a_cnt_range, clk, arst_n, vld, cnt <= MAX_CNT, "count beyond depth")
	`DWIS_ASSERT_IMP(a_full_cnt, clk, arst_n, vld && stat == ST_FULL, cnt == MAX_CNT, "full, not full")
	`DWIS_ASSERT_IMP(a_empty_cnt, clk, arst_n, vld && stat == ST_EMPTY, cnt == '0, "empty, not empty")
	`DWIS_ASSERT_IMP(a_found_ok, clk, arst_n, vld && found, stat == ST_OK && rd == '0, "bad found")

endmodule

bind deque_with_index_and_search_unit dwis_checker u_dwis_checker (.*);

`default_nettype wire
